/* design/ffra_pkg.sv */
// Shared types and defaults for the first-fit range allocator
`timescale 1ns / 1ps
package ffra_pkg;

   localparam int MAX_RANGES_DEF  = 64;
   localparam int OFFSET_BITS_DEF = 24;

   typedef enum logic {
      OP_ALLOC = 1'b0,
      OP_FREE  = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      STAT_OK     = 2'd0,
      STAT_NO_FIT = 2'd1,
      STAT_FULL   = 2'd2
   } stat_type;

   typedef enum logic [2:0] {
      HIT_NONE,
      HIT_EXACT,
      HIT_SHRINK,
      HIT_BELOW,
      HIT_ABOVE
   } hit_type;

   typedef enum logic [2:0] {
      S_INIT,
      S_IDLE,
      S_SCAN,
      S_APPLY,
      S_MOVE,
      S_FINISH,
      S_OUT
   } fsm_type;

endpackage

/* design/ffra_req_if.sv */
// Request channel: opcode, length and block offset
`timescale 1ns / 1ps
interface ffra_req_if #(
   parameter int OFS_W = ffra_pkg::OFFSET_BITS_DEF
);
   logic             valid;
   logic             ready;
   logic             opcode;
   logic [OFS_W:0]   length;
   logic [OFS_W-1:0] block_offset;

   modport source (output valid, output opcode, output length, output block_offset,
                   input ready);
   modport sink   (input valid, input opcode, input length, input block_offset,
                   output ready);
endinterface

/* design/ffra_rsp_if.sv */
// Response channel: status, allocated offset and total free length
`timescale 1ns / 1ps
interface ffra_rsp_if #(
   parameter int OFS_W = ffra_pkg::OFFSET_BITS_DEF
);
   logic             valid;
   logic             ready;
   logic [1:0]       status;
   logic [OFS_W-1:0] alloc_offset;
   logic [OFS_W:0]   free_total;

   modport source (output valid, output status, output alloc_offset, output free_total,
                   input ready);
   modport sink   (input valid, input status, input alloc_offset, input free_total,
                   output ready);
endinterface

/* design/first_fit_range_allocator_core.sv */
// First-fit free range allocator: free table, scan sequencer and response register
//
//  channel   | dir | handshake     | beat contents
//  ----------+-----+---------------+-------------------------------------------
//  req_bus   | in  | valid / ready | opcode, length, block_offset
//  rsp_bus   | out | valid / ready | status, alloc_offset, free_total
//  csr_*     | in  | csr_we        | csr_wdata = pool size (reloads free table)
//
// During a request the single compare unit walks the free table one entry per cycle
// through its registered read port; apply, move (exact hits only), total update and
// output follow.
// After reset the init state loads entry 0 before the first request is taken.
// Requests are taken only when the sequencer is idle; a response waiting on
// rsp_bus.ready holds the sequencer in its output state.
`timescale 1ns / 1ps
module first_fit_range_allocator_core #(
   parameter int MAX_RANGES  = ffra_pkg::MAX_RANGES_DEF,
   parameter int OFFSET_BITS = ffra_pkg::OFFSET_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [OFFSET_BITS:0] csr_wdata,
   ffra_req_if.sink             req_bus,
   ffra_rsp_if.source           rsp_bus
);
   import ffra_pkg::*;

   localparam int LEN_W = OFFSET_BITS + 1;
   localparam int IDX_W = $clog2(MAX_RANGES);
   localparam int CNT_W = $clog2(MAX_RANGES + 1);
   localparam int TOT_W = LEN_W + IDX_W;
   localparam int ENT_W = OFFSET_BITS + LEN_W;
   localparam logic [LEN_W-1:0] POOL_MAX = {1'b1, {OFFSET_BITS{1'b0}}};

   // free table: {start, length}
   logic [ENT_W-1:0] range_mem [MAX_RANGES];

   fsm_type              state_ff, state_in;
   logic [CNT_W-1:0]     idx_ff, idx_in;
   logic                 pend_ff, pend_in;
   logic [IDX_W-1:0]     chk_ff, chk_in;
   op_type               op_ff, op_in;
   logic [LEN_W-1:0]     len_ff, len_in;
   logic [OFFSET_BITS-1:0] ofs_ff, ofs_in;
   logic [LEN_W:0]       end_ff, end_in;
   hit_type              kind_ff, kind_in;
   logic [IDX_W-1:0]     hit_idx_ff, hit_idx_in;
   logic [OFFSET_BITS-1:0] hit_start_ff, hit_start_in;
   logic [LEN_W-1:0]     hit_len_ff, hit_len_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [TOT_W-1:0]     total_ff, total_in;
   logic [LEN_W-1:0]     pool_ff, pool_in;
   logic [LEN_W-1:0]     delta_ff, delta_in;
   logic                 sub_ff, sub_in;
   stat_type             stat_ff, stat_in;
   logic [OFFSET_BITS-1:0] aofs_ff, aofs_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   stat_type             rsp_status_ff, rsp_status_in;
   logic [OFFSET_BITS-1:0] rsp_ofs_ff, rsp_ofs_in;
   logic [LEN_W-1:0]     rsp_total_ff, rsp_total_in;
   logic [ENT_W-1:0]     rd_data_ff;

   logic                 wr_en;
   logic [IDX_W-1:0]     wr_addr;
   logic [ENT_W-1:0]     wr_data;
   logic [IDX_W-1:0]     rd_addr;

   logic                 req_fire;
   logic                 out_free;
   logic [OFFSET_BITS-1:0] ent_start;
   logic [LEN_W-1:0]     ent_len;
   logic                 is_below, is_above, is_eq, is_gt;
   logic                 scan_hit, scan_miss;
   hit_type              scan_kind;
   logic [LEN_W:0]       mrg_sum;
   logic [LEN_W-1:0]     mrg_len;
   logic [LEN_W-1:0]     mrg_delta;

   function automatic logic [IDX_W-1:0] hit_idx_w(input logic [CNT_W-1:0] n);
      return n[IDX_W-1:0];
   endfunction

   assign req_fire = req_bus.valid && req_bus.ready;
   assign out_free = !rsp_valid_ff || rsp_bus.ready;

   assign ent_start = rd_data_ff[ENT_W-1:LEN_W];
   assign ent_len   = rd_data_ff[LEN_W-1:0];

   // single compare unit shared by both opcodes
   assign is_eq    = ent_len == len_ff;
   assign is_gt    = ent_len > len_ff;
   assign is_below = ({2'b00, ent_start} + {1'b0, ent_len}) == {2'b00, ofs_ff};
   assign is_above = end_ff == {2'b00, ent_start};

   always_comb begin
      scan_kind = HIT_NONE;
      if (op_ff == OP_ALLOC) begin
         if (is_eq) begin
            scan_kind = HIT_EXACT;
         end else if (is_gt) begin
            scan_kind = HIT_SHRINK;
         end
      end else begin
         if (is_below) begin
            scan_kind = HIT_BELOW;
         end else if (is_above) begin
            scan_kind = HIT_ABOVE;
         end
      end
   end

   assign scan_hit  = pend_ff && (scan_kind != HIT_NONE);
   assign scan_miss = !pend_ff && (idx_ff >= count_ff);

   // merged length saturates at the all-ones length
   assign mrg_sum   = {1'b0, hit_len_ff} + {1'b0, len_ff};
   assign mrg_len   = mrg_sum[LEN_W] ? {LEN_W{1'b1}} : mrg_sum[LEN_W-1:0];
   assign mrg_delta = mrg_sum[LEN_W] ? ~hit_len_ff : len_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_INIT: begin
            state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_fire) begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (scan_hit || scan_miss) begin
               state_in = S_APPLY;
            end
         end
         S_APPLY: begin
            state_in = (kind_ff == HIT_EXACT) ? S_MOVE : S_FINISH;
         end
         S_MOVE: begin
            state_in = S_FINISH;
         end
         S_FINISH: begin
            state_in = S_OUT;
         end
         S_OUT: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // datapath and table control
   always_comb begin
      idx_in        = idx_ff;
      pend_in       = pend_ff;
      chk_in        = chk_ff;
      op_in         = op_ff;
      len_in        = len_ff;
      ofs_in        = ofs_ff;
      end_in        = end_ff;
      kind_in       = kind_ff;
      hit_idx_in    = hit_idx_ff;
      hit_start_in  = hit_start_ff;
      hit_len_in    = hit_len_ff;
      count_in      = count_ff;
      total_in      = total_ff;
      pool_in       = pool_ff;
      delta_in      = delta_ff;
      sub_in        = sub_ff;
      stat_in       = stat_ff;
      aofs_in       = aofs_ff;
      rsp_status_in = rsp_status_ff;
      rsp_ofs_in    = rsp_ofs_ff;
      rsp_total_in  = rsp_total_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      wr_en         = 1'b0;
      wr_addr       = '0;
      wr_data       = '0;
      rd_addr       = idx_ff[IDX_W-1:0];

      case (state_ff)
         S_INIT: begin
            wr_en   = 1'b1;
            wr_data = {{OFFSET_BITS{1'b0}}, pool_ff};
         end
         S_IDLE: begin
            if (req_fire) begin
               op_in    = op_type'(req_bus.opcode);
               len_in   = req_bus.length;
               ofs_in   = req_bus.block_offset;
               end_in   = {2'b00, req_bus.block_offset} + {1'b0, req_bus.length};
               idx_in   = '0;
               pend_in  = 1'b0;
               delta_in = '0;
               sub_in   = 1'b0;
               stat_in  = STAT_OK;
               aofs_in  = '0;
            end
         end
         S_SCAN: begin
            if (scan_hit) begin
               kind_in      = scan_kind;
               hit_idx_in   = chk_ff;
               hit_start_in = ent_start;
               hit_len_in   = ent_len;
               pend_in      = 1'b0;
            end else if (scan_miss) begin
               kind_in = HIT_NONE;
            end else if (idx_ff < count_ff) begin
               // read of the next entry overlaps the compare of this one
               chk_in  = idx_ff[IDX_W-1:0];
               idx_in  = idx_ff + CNT_W'(1);
               pend_in = 1'b1;
            end else begin
               pend_in = 1'b0;
            end
         end
         S_APPLY: begin
            case (kind_ff)
               HIT_EXACT: begin
                  aofs_in  = hit_start_ff;
                  delta_in = len_ff;
                  sub_in   = 1'b1;
                  count_in = count_ff - CNT_W'(1);
                  rd_addr  = hit_idx_w(count_ff - CNT_W'(1));
               end
               HIT_SHRINK: begin
                  aofs_in  = hit_start_ff;
                  delta_in = len_ff;
                  sub_in   = 1'b1;
                  wr_en    = 1'b1;
                  wr_addr  = hit_idx_ff;
                  wr_data  = {hit_start_ff + len_ff[OFFSET_BITS-1:0], hit_len_ff - len_ff};
               end
               HIT_BELOW: begin
                  delta_in = mrg_delta;
                  wr_en    = 1'b1;
                  wr_addr  = hit_idx_ff;
                  wr_data  = {hit_start_ff, mrg_len};
               end
               HIT_ABOVE: begin
                  delta_in = mrg_delta;
                  wr_en    = 1'b1;
                  wr_addr  = hit_idx_ff;
                  wr_data  = {ofs_ff, mrg_len};
               end
               default: begin
                  if (op_ff == OP_ALLOC) begin
                     stat_in = STAT_NO_FIT;
                  end else if (count_ff >= CNT_W'(MAX_RANGES)) begin
                     stat_in = STAT_FULL;
                  end else begin
                     delta_in = len_ff;
                     count_in = count_ff + CNT_W'(1);
                     wr_en    = 1'b1;
                     wr_addr  = count_ff[IDX_W-1:0];
                     wr_data  = {ofs_ff, len_ff};
                  end
               end
            endcase
         end
         S_MOVE: begin
            // last entry fills the hole unless it was the hit itself
            if (hit_idx_ff != count_ff[IDX_W-1:0]) begin
               wr_en   = 1'b1;
               wr_addr = hit_idx_ff;
               wr_data = rd_data_ff;
            end
         end
         S_FINISH: begin
            if (sub_ff) begin
               total_in = total_ff - {{IDX_W{1'b0}}, delta_ff};
            end else begin
               total_in = total_ff + {{IDX_W{1'b0}}, delta_ff};
            end
         end
         S_OUT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = stat_ff;
               rsp_ofs_in    = aofs_ff;
               rsp_total_in  = (|total_ff[TOT_W-1:LEN_W]) ? {LEN_W{1'b1}}
                                                         : total_ff[LEN_W-1:0];
            end
         end
         default: begin
         end
      endcase

      // pool size write reloads the table as one range
      if (csr_we) begin
         pool_in  = (csr_wdata > POOL_MAX) ? POOL_MAX : csr_wdata;
         count_in = CNT_W'(1);
         total_in = {{IDX_W{1'b0}}, pool_in};
         wr_en    = 1'b1;
         wr_addr  = '0;
         wr_data  = {{OFFSET_BITS{1'b0}}, pool_in};
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         range_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= range_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         pend_ff      <= 1'b0;
         count_ff     <= CNT_W'(1);
         total_ff     <= {{IDX_W{1'b0}}, POOL_MAX};
         pool_ff      <= POOL_MAX;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         count_ff     <= count_in;
         total_ff     <= total_in;
         pool_ff      <= pool_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      chk_ff        <= chk_in;
      op_ff         <= op_in;
      len_ff        <= len_in;
      ofs_ff        <= ofs_in;
      end_ff        <= end_in;
      kind_ff       <= kind_in;
      hit_idx_ff    <= hit_idx_in;
      hit_start_ff  <= hit_start_in;
      hit_len_ff    <= hit_len_in;
      delta_ff      <= delta_in;
      sub_ff        <= sub_in;
      stat_ff       <= stat_in;
      aofs_ff       <= aofs_in;
      rsp_status_ff <= rsp_status_in;
      rsp_ofs_ff    <= rsp_ofs_in;
      rsp_total_ff  <= rsp_total_in;
   end

   assign req_bus.ready        = state_ff == S_IDLE;
   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.status       = rsp_status_ff;
   assign rsp_bus.alloc_offset = rsp_ofs_ff;
   assign rsp_bus.free_total   = rsp_total_ff;

endmodule

/* design/ffra_checker.sv */
// Port-level checks for the range allocator, bound to the allocator core
`timescale 1ns / 1ps
module ffra_checker #(
   parameter int OFFSET_BITS = ffra_pkg::OFFSET_BITS_DEF
) (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic [1:0]             rsp_status,
   input logic [OFFSET_BITS-1:0] rsp_alloc_offset,
   input logic [OFFSET_BITS:0]   rsp_free_total
);
   import ffra_pkg::*;

   // one request in flight: the scan starts, so ready drops
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("ffra: ready held after a request beat");

   // a failed or dropped request never reports an offset
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != STAT_OK) |-> (rsp_alloc_offset == '0))
      else $error("ffra: offset reported on failed request");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == STAT_OK || rsp_status == STAT_NO_FIT ||
                     rsp_status == STAT_FULL))
      else $error("ffra: undefined status code");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_free_total)))
      else $error("ffra: stalled response changed");

endmodule

bind first_fit_range_allocator_core ffra_checker #(
   .OFFSET_BITS (OFFSET_BITS)
) u_ffra_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_bus.valid),
   .req_ready        (req_bus.ready),
   .rsp_valid        (rsp_bus.valid),
   .rsp_ready        (rsp_bus.ready),
   .rsp_status       (rsp_bus.status),
   .rsp_alloc_offset (rsp_bus.alloc_offset),
   .rsp_free_total   (rsp_bus.free_total)
);
